[hw/rtl/hdlc_frame_encoder_assert.svh]
// assertion macros for the hdlc frame encoder
// used by hdlc_frame_encoder.sv, no other dependencies
`ifndef HDLC_FRAME_ENCODER_ASSERT_SVH
`define HDLC_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HFE_ASSERT_IMP(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("hfe assertion failed");

// next-cycle implication, checked out of reset
`define HFE_ASSERT_NXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("hfe assertion failed");

`endif

[hw/rtl/hfe_pkg.sv]
// types, constants and fcs function for the hdlc frame encoder
// no dependencies
`timescale 1ns / 1ps

package hfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_MASK  = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;

  // command handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        has_open;
    logic        has_data;
    logic        has_close;
    logic [15:0] fcs;
  } cmd_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] c;
    c = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/hfe_front.sv]
// front end: accepts payload words, tracks frame state and running fcs
// depends on hfe_pkg
`timescale 1ns / 1ps

module hfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              in_empty_frame,
  input  logic              q_full,
  output logic              q_push,
  output hfe_pkg::cmd_t     q_wdata
);

  logic        inside_r, inside_nxt;
  logic [15:0] fcs_r, fcs_nxt;
  logic [15:0] base;
  logic [15:0] upd;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    base = inside_r ? fcs_r : hfe_pkg::FCS_INIT;
    upd  = hfe_pkg::fcs_update(base, in_data_byte);

    q_wdata.data     = in_data_byte;
    q_wdata.has_open = !inside_r;
    if (in_empty_frame) begin
      q_wdata.has_data  = 1'b0;
      q_wdata.has_close = 1'b1;
      q_wdata.fcs       = ~base;
    end else begin
      q_wdata.has_data  = 1'b1;
      q_wdata.has_close = in_last_byte;
      q_wdata.fcs       = ~upd;
    end

    inside_nxt = inside_r;
    fcs_nxt    = fcs_r;
    if (q_push) begin
      if (in_empty_frame || in_last_byte) begin
        inside_nxt = 1'b0;
        fcs_nxt    = hfe_pkg::FCS_INIT;
      end else begin
        inside_nxt = 1'b1;
        fcs_nxt    = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      fcs_r    <= hfe_pkg::FCS_INIT;
    end else begin
      inside_r <= inside_nxt;
      fcs_r    <= fcs_nxt;
    end
  end

endmodule

[hw/rtl/hfe_cmd_queue.sv]
// two-entry queue of commands between front and back
// depends on hfe_pkg
`timescale 1ns / 1ps

module hfe_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  hfe_pkg::cmd_t q_wdata,
  output logic          q_full,
  input  logic          q_pop,
  output hfe_pkg::cmd_t q_rdata,
  output logic          q_empty
);

  hfe_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign q_rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ q_push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + {1'b0, q_push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hw/rtl/hfe_back.sv]
// back end: expands a command into its flags and escaped data and fcs bytes
// depends on hfe_pkg
`timescale 1ns / 1ps

module hfe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  hfe_pkg::cmd_t q_rdata,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_frame_closed
);

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } phase_t;

  hfe_pkg::cmd_t cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  phase_t        phase_r, phase_nxt;
  logic          esc_r, esc_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_closed_r, out_closed_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          out_ready, fire, can_esc, need_esc, done_sym, load;
  logic [7:0]    raw, byte_val;
  phase_t        next_ph, start_ph;

  assign empty            = !out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_run_last     = out_last_r;
  assign out_frame_closed = out_closed_r;

  always_comb begin
    out_ready = !out_valid_r || pop;
    fire      = cur_valid_r && out_ready;

    unique case (phase_r)
      PH_OPEN:   begin raw = hfe_pkg::FLAG_BYTE; can_esc = 1'b0; end
      PH_DATA:   begin raw = cur_r.data;         can_esc = 1'b1; end
      PH_FCS_LO: begin raw = cur_r.fcs[7:0];     can_esc = 1'b1; end
      PH_FCS_HI: begin raw = cur_r.fcs[15:8];    can_esc = 1'b1; end
      PH_CLOSE:  begin raw = hfe_pkg::FLAG_BYTE; can_esc = 1'b0; end
      default:   begin raw = hfe_pkg::FLAG_BYTE; can_esc = 1'b0; end
    endcase

    need_esc = can_esc && !esc_r &&
               (raw == hfe_pkg::FLAG_BYTE || raw == hfe_pkg::ESC_BYTE);
    byte_val = need_esc ? hfe_pkg::ESC_BYTE : (esc_r ? (raw ^ hfe_pkg::ESC_MASK) : raw);

    done_sym = 1'b0;
    unique case (phase_r)
      PH_OPEN: begin
        next_ph = cur_r.has_data ? PH_DATA : PH_FCS_LO;
      end
      PH_DATA: begin
        next_ph  = PH_FCS_LO;
        done_sym = !cur_r.has_close;
      end
      PH_FCS_LO: next_ph = PH_FCS_HI;
      PH_FCS_HI: next_ph = PH_CLOSE;
      PH_CLOSE: begin
        next_ph  = PH_CLOSE;
        done_sym = 1'b1;
      end
      default: begin
        next_ph  = PH_CLOSE;
        done_sym = 1'b1;
      end
    endcase
    done_sym = done_sym && !need_esc;

    start_ph = q_rdata.has_open ? PH_OPEN : (q_rdata.has_data ? PH_DATA : PH_FCS_LO);

    load  = !cur_valid_r || (fire && done_sym);
    q_pop = load && !q_empty;

    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_closed_nxt = out_closed_r;
    out_valid_nxt  = out_valid_r;
    if (fire) begin
      out_byte_nxt   = byte_val;
      out_last_nxt   = done_sym;
      out_closed_nxt = (phase_r == PH_CLOSE);
      out_valid_nxt  = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    phase_nxt     = phase_r;
    esc_nxt       = esc_r;
    if (fire) begin
      if (need_esc) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt   = 1'b0;
        phase_nxt = next_ph;
      end
    end
    if (load) begin
      cur_valid_nxt = !q_empty;
      cur_nxt       = q_rdata;
      phase_nxt     = start_ph;
      esc_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= PH_OPEN;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_closed_r <= out_closed_nxt;
  end

endmodule

[hw/rtl/hdlc_frame_encoder.sv]
// hdlc frame encoder with byte stuffing and ppp fcs-16
// usage: input channel push/full takes one payload word (data byte, last flag, empty-frame
// flag); result channel empty/pop delivers framed bytes in order, the oldest on out_byte
// the front keeps frame state and the running fcs and hands a command per word to a
// two-entry queue; the back expands it into opening flag, escaped payload byte, escaped fcs
// low and high bytes and closing flag as selected, one output word per cycle if not stalled
// an item's first byte passes the queue, the back's command register and output register
// throughput: an item yields 1 to 8 output words; unless stalled the back sends one per
// cycle, so a plain payload byte sustains one item per cycle and an escaped one does not
// out_run_last marks the final word of each item, out_frame_closed the closing flag
// reset: synchronous active-low rst_n closes any open frame state, sets the fcs to 0xFFFF
// and empties the queue and output register
// stall: while pop is held low the output register and back hold; the queue fills and
// full rises after two further items, without loss
// depends on hfe_pkg, hfe_front, hfe_cmd_queue, hfe_back, hdlc_frame_encoder_assert.svh
`timescale 1ns / 1ps
`include "hdlc_frame_encoder_assert.svh"

module hdlc_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_empty_frame,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_closed
);

  hfe_pkg::cmd_t q_wdata;
  hfe_pkg::cmd_t q_rdata;
  logic          q_push, q_pop, q_full, q_empty;

  hfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_empty_frame (in_empty_frame),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  hfe_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  hfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_frame_closed (out_frame_closed)
  );

  `HFE_ASSERT_IMP(a_close_is_last, clk, rst_n, !empty && out_frame_closed, out_run_last)
  `HFE_ASSERT_IMP(a_close_is_flag, clk, rst_n, !empty && out_frame_closed, out_byte == hfe_pkg::FLAG_BYTE)
  `HFE_ASSERT_IMP(a_esc_not_last, clk, rst_n, !empty && out_byte == hfe_pkg::ESC_BYTE, !out_run_last)
  `HFE_ASSERT_NXT(a_esc_followed, clk, rst_n, !empty && pop && out_byte == hfe_pkg::ESC_BYTE, !empty)

endmodule
